/* rtl/core/piecewise_linear_curve_sampler_unit_assert.svh */
// Assertion macros for the piecewise-linear curve sampler.
`ifndef PIECEWISE_LINEAR_CURVE_SAMPLER_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define PLCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define PLCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/plcs_pkg.sv */
// Shared types and constants for the piecewise-linear curve sampler.
package plcs_pkg;

  localparam int unsigned IdxW     = 6;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PiuW     = 7;
  localparam int unsigned DefMaxPoints = 64;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef enum logic [0:0] {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  // One queued item. For a write, arg_a is the key and arg_b the value.
  // For a sample, arg_a is x and arg_b is unused.
  typedef struct packed {
    req_e                    kind;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] arg_a;
    logic signed [DataW-1:0] arg_b;
  } item_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } q_stat_t;

endpackage

/* rtl/core/piecewise_linear_curve_sampler_unit.sv */
// Top level of the piecewise-linear curve sampler: front queue, back end, config register.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   req_type, point_index, point_key, ...
//   out      output     out_valid_o / out_stall_i sample_y
//   cfg      input      cfg_valid_i / cfg_ready_o points_in_use
//
// A write item is taken in S_POP and the back end stays there. A sample item that clamps to
// an end point passes S_RDK0, S_CK0 and, at the upper end, S_CKL, then S_OUT; one that
// interpolates runs p search probes (S_SRCH, S_CMP) through the single table read port, p at
// most ceil(log2(points - 1)), then S_LO, S_HI, the divider (S_DIV), the multiply (S_MUL),
// S_FIN, S_OUT. out_stall_i holds a waiting result in S_OUT; the two-item queue keeps taking
// input until it is full. Reset clears queue and sequencer and sets points_in_use to one.
`include "piecewise_linear_curve_sampler_unit_assert.svh"

module piecewise_linear_curve_sampler_unit #(
  parameter int unsigned MAX_POINTS = plcs_pkg::DefMaxPoints
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [5:0]         point_index_i,
  input  logic signed [31:0] point_key_i,
  input  logic signed [31:0] point_value_i,
  input  logic signed [31:0] sample_x_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sample_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         points_in_use_i
);
  import plcs_pkg::*;

  logic       q_valid;
  logic       q_pop;
  item_t      q_item;
  q_stat_t    q_stat;
  logic [6:0] piu_q;

  // Always writable; users must change the count register only while idle (not checked).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= 7'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      piu_q <= points_in_use_i;
    end
  end

  plcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .point_index_i (point_index_i),
    .point_key_i   (point_key_i),
    .point_value_i (point_value_i),
    .sample_x_i    (sample_x_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop),
    .q_stat_o      (q_stat)
  );

  plcs_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .points_in_use_i (piu_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_y_o      (sample_y_o)
  );

  // The back end only takes an item from a non-empty queue.
  `PLCS_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid && !q_stat.empty, "pop from empty queue")
  // The queue never holds more than its depth.
  `PLCS_ASSERT_NOW(a_cnt_bound, 1'b1, q_stat.count <= QCntW'(QDepth), "queue overfilled")
  // A result never shows while the back end takes an item, nor right after.
  `PLCS_ASSERT_NOW(a_no_pop_out, out_valid_o, !q_pop, "pop while result pending")
  `PLCS_ASSERT_NEXT(a_pop_no_out, q_pop, !out_valid_o, "result right after pop")

endmodule

/* rtl/core/plcs_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module plcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [5:0]          point_index_i,
  input  logic signed [31:0]  point_key_i,
  input  logic signed [31:0]  point_value_i,
  input  logic signed [31:0]  sample_x_i,
  output logic                q_valid_o,
  output plcs_pkg::item_t     q_item_o,
  input  logic                q_pop_i,
  output plcs_pkg::q_stat_t   q_stat_o
);
  import plcs_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  item_t            entry_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  item_t            new_item;
  logic             push;

  always_comb begin
    new_item.idx = point_index_i;
    if (req_type_i == REQ_SAMPLE) begin
      new_item.kind  = REQ_SAMPLE;
      new_item.arg_a = sample_x_i;
      new_item.arg_b = '0;
    end else begin
      new_item.kind  = REQ_WRITE;
      new_item.arg_a = point_key_i;
      new_item.arg_b = point_value_i;
    end
  end

  assign in_stall_o = (cnt_q == QCntW'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

  assign q_stat_o.count = cnt_q;
  assign q_stat_o.full  = in_stall_o;
  assign q_stat_o.empty = !q_valid_o;

endmodule

/* rtl/core/plcs_back.sv */
// Back end: point table, binary search, serial divider and the final multiply.
module plcs_back #(
  parameter int unsigned MAX_POINTS = plcs_pkg::DefMaxPoints
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [6:0]         points_in_use_i,
  input  logic               q_valid_i,
  input  plcs_pkg::item_t    q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sample_y_o
);
  import plcs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  typedef enum logic [3:0] {
    S_POP, S_RDK0, S_CK0, S_CKL, S_SRCH, S_CMP, S_LO, S_HI, S_DIV, S_MUL, S_FIN, S_OUT
  } state_e;

  state_e                    state_q;
  logic [2*DataW-1:0]        mem [MAX_POINTS];
  logic [2*DataW-1:0]        rd_q;
  logic [AW-1:0]             ra;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [31:0]               n32;
  logic [AW-1:0]             last;
  logic [AW-1:0]             lo_q, hi_q, mid, span;
  logic signed [DataW-1:0]   x_q, klo_q, vlo_q, y_q;
  logic [DataW-1:0]          den_q, quo_q;
  logic [DataW:0]            rem_q, rem_sh;
  logic signed [DataW:0]     dlt_q, dlt_neg;
  logic [4:0]                cnt_q;
  logic [2*DataW-1:0]        prod_q;
  logic [DataW-1:0]          mag;
  logic [DataW:0]            qup;
  logic signed [DataW-1:0]   rd_key, rd_val;
  logic signed [DataW:0]     x_m_klo, khi_m_klo;

  assign rd_key = rd_q[2*DataW-1:DataW];
  assign rd_val = rd_q[DataW-1:0];

  // Effective point count, clamped to one and to the table depth.
  always_comb begin
    n32 = 32'(points_in_use_i);
    if (n32 == 32'd0) begin
      n32 = 32'd1;
    end else if (n32 > 32'(MAX_POINTS)) begin
      n32 = 32'(MAX_POINTS);
    end
  end
  assign last = AW'(n32 - 32'd1);

  assign span = hi_q - lo_q;
  assign mid  = lo_q + (span >> 1);

  assign x_m_klo   = {x_q[DataW-1], x_q} - {klo_q[DataW-1], klo_q};
  assign khi_m_klo = {rd_key[DataW-1], rd_key} - {klo_q[DataW-1], klo_q};
  assign rem_sh    = {rem_q[DataW-1:0], 1'b0};
  assign dlt_neg   = -dlt_q;
  assign mag       = dlt_q[DataW] ? dlt_neg[DataW-1:0] : dlt_q[DataW-1:0];
  assign qup       = {1'b0, prod_q[2*DataW-1:DataW]} + (DataW+1)'(|prod_q[DataW-1:0]);

  assign q_pop_o = (state_q == S_POP) && q_valid_i;
  assign we  = q_pop_o && (q_item_i.kind == REQ_WRITE) &&
               (32'(q_item_i.idx) < 32'(MAX_POINTS));
  assign wa  = AW'(q_item_i.idx);

  always_comb begin
    case (state_q)
      S_CK0:   ra = last;
      S_SRCH:  ra = (span > AW'(1)) ? mid : lo_q;
      S_LO:    ra = hi_q;
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= {q_item_i.arg_a, q_item_i.arg_b};
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_POP;
      lo_q    <= '0;
      hi_q    <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_POP: begin
          if (q_valid_i && q_item_i.kind == REQ_SAMPLE) begin
            x_q     <= q_item_i.arg_a;
            state_q <= S_RDK0;
          end
        end
        S_RDK0: state_q <= S_CK0;
        S_CK0: begin
          if (x_q <= rd_key) begin
            y_q     <= rd_val;
            state_q <= S_OUT;
          end else begin
            state_q <= S_CKL;
          end
        end
        S_CKL: begin
          if (x_q >= rd_key) begin
            y_q     <= rd_val;
            state_q <= S_OUT;
          end else begin
            lo_q    <= '0;
            hi_q    <= last;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          state_q <= (span > AW'(1)) ? S_CMP : S_LO;
        end
        S_CMP: begin
          if (rd_key <= x_q) begin
            lo_q <= mid;
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_LO: begin
          klo_q   <= rd_key;
          vlo_q   <= rd_val;
          state_q <= S_HI;
        end
        S_HI: begin
          den_q   <= khi_m_klo[DataW-1:0];
          rem_q   <= {1'b0, x_m_klo[DataW-1:0]};
          dlt_q   <= {rd_val[DataW-1], rd_val} - {vlo_q[DataW-1], vlo_q};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[DataW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[DataW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(DataW - 1)) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= (2*DataW)'(mag) * (2*DataW)'(quo_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (dlt_q[DataW]) begin
            y_q <= vlo_q - qup[DataW-1:0];
          end else begin
            y_q <= vlo_q + prod_q[2*DataW-1:DataW];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_POP;
          end
        end
        default: state_q <= S_POP;
      endcase
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign sample_y_o  = y_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the piecewise-linear curve sampler unit.
module tb;
  import plcs_pkg::*;

  localparam int unsigned NumPoints  = 64;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 120;

  // One item as the sender offers it.
  typedef struct {
    req_e               kind;
    logic [5:0]         idx;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic signed [31:0] x;
  } curve_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = 1'b0;
  logic [5:0]         point_index = '0;
  logic signed [31:0] point_key = '0;
  logic signed [31:0] point_value = '0;
  logic signed [31:0] sample_x = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] sample_y;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_points = 7'd1;

  piecewise_linear_curve_sampler_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .point_index_i   (point_index),
    .point_key_i     (point_key),
    .point_value_i   (point_value),
    .sample_x_i      (sample_x),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sample_y_o      (sample_y),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .points_in_use_i (cfg_points)
  );

  // Predictor state: the curve table and the point count as the block sees them.
  logic signed [31:0] key_tab [NumPoints];
  logic signed [31:0] val_tab [NumPoints];
  logic [6:0]         points_in_use = 7'd1;

  // Stimulus-side view of the curve, used only to aim samples and writes.
  logic signed [31:0] plan_key [NumPoints];

  curve_req_t         pending_reqs[$];
  curve_req_t         cur_req;
  logic signed [31:0] expected_y[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned writes_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Computes the curve value at x from the predictor's table and point count.
  function automatic logic signed [31:0] curve_at(input logic signed [31:0] x);
    int unsigned n, lo, hi, mid;
    longint      klo, khi, vlo, vhi, d;
    bit [63:0]   num, den, t, mag, prod, q;
    n = (points_in_use == 0) ? 1 : ((points_in_use > NumPoints) ? NumPoints : points_in_use);
    if (x <= key_tab[0]) return val_tab[0];
    if (x >= key_tab[n-1]) return val_tab[n-1];
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (key_tab[mid] <= x) lo = mid;
      else hi = mid;
    end
    klo = key_tab[lo];
    khi = key_tab[hi];
    vlo = val_tab[lo];
    vhi = val_tab[hi];
    num = 64'(longint'(x) - klo) << 32;
    den = 64'(khi - klo);
    t = num / den;
    d = vhi - vlo;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    prod = mag * t;
    q = prod >> 32;
    if (d >= 0) return 32'(vlo + longint'(q));
    if (prod[31:0] != 0) q = q + 1;
    return 32'(vlo - longint'(q));
  endfunction

  // Applies one accepted item to the predictor.
  function automatic void apply_req(input curve_req_t r);
    if (r.kind == REQ_WRITE) begin
      key_tab[r.idx] = r.key;
      val_tab[r.idx] = r.value;
    end else begin
      expected_y.push_back(curve_at(r.x));
    end
  endfunction

  function automatic curve_req_t write_req(input int unsigned i, input logic signed [31:0] k,
                                           input logic signed [31:0] v);
    curve_req_t r;
    r.kind = REQ_WRITE;
    r.idx = 6'(i);
    r.key = k;
    r.value = v;
    r.x = $urandom;
    plan_key[i] = k;
    return r;
  endfunction

  function automatic curve_req_t sample_req(input logic signed [31:0] x);
    curve_req_t r;
    r.kind = REQ_SAMPLE;
    r.idx = 6'($urandom);
    r.key = $urandom;
    r.value = $urandom;
    r.x = x;
    return r;
  endfunction

  // Random traffic. Most writes keep a point's key so that the keys stay ordered and
  // samples land inside segments; a few scramble a key. Most samples aim near a key.
  function automatic curve_req_t random_req();
    int unsigned j, sel;
    j = $urandom_range(NumPoints - 1);
    sel = $urandom_range(99);
    if (sel < 20) return write_req(j, plan_key[j], $urandom);
    if (sel < 25) return write_req(j, $urandom, $urandom);
    if (sel < 80) return sample_req(plan_key[j] + $signed($urandom_range(8000000)) - 4000000);
    if (sel < 90) return sample_req(plan_key[j] + $signed($urandom_range(2)) - 1);
    return sample_req($urandom);
  endfunction

  // Sender: holds the item until accepted, then offers the next one or idles.
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      apply_req(cur_req);
      if (cur_req.kind == REQ_WRITE) writes_sent++;
      else samples_sent++;
    end
    if (!in_valid || !in_stall) begin
      if (rst_n && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        in_valid    <= 1'b1;
        req_type    <= cur_req.kind;
        point_index <= cur_req.idx;
        point_key   <= cur_req.key;
        point_value <= cur_req.value;
        sample_x    <= cur_req.x;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random stalls, plus a long hold-off on request that lets the
  // block fill up and push back on its input.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_go) begin
      hold_cnt <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_y.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result sample_y=%0d", sample_y);
      end else begin
        logic signed [31:0] want;
        want = expected_y.pop_front();
        if (sample_y !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: sample_y mismatch: expected %0d, got %0d", want, sample_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               expected_y.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Checks at the falling edge, where the sender's and checker's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_y.size() != 0) @(negedge clk);
    // A trailing write produces no result, so give the back end time to settle.
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_points_in_use(input logic [6:0] v);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_points <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    points_in_use = v;
  endtask

  task automatic run_phase(input logic [6:0] count, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_items);
    set_points_in_use(count);
    @(posedge clk);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (n_items) pending_reqs.push_back(random_req());
    wait_drained();
  endtask

  initial begin
    int unsigned step;
    for (int i = 0; i < NumPoints; i++) begin
      key_tab[i] = '0;
      val_tab[i] = '0;
      plan_key[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Load the whole table with strictly increasing keys spanning the full range,
    // so no sample can ever read an entry that was never written.
    step = 68174084;
    for (int i = 0; i < NumPoints; i++)
      pending_reqs.push_back(write_req(i, -32'sd2147483648 + 32'(i * step), $urandom));
    pending_reqs.push_back(write_req(NumPoints - 1, 32'sh7fffffff, 32'sh80000000));
    // Largest rising and falling value steps on the first two segments.
    pending_reqs.push_back(write_req(0, 32'sh80000000, 32'sh80000000));
    pending_reqs.push_back(write_req(1, plan_key[1], 32'sh7fffffff));
    pending_reqs.push_back(write_req(2, plan_key[2], 32'sh80000000));
    wait_drained();
    set_points_in_use(7'd64);

    // Directed samples: range ends, exact keys, just either side of keys, segment middles.
    pending_reqs.push_back(sample_req(32'sh80000000));
    pending_reqs.push_back(sample_req(32'sh7fffffff));
    pending_reqs.push_back(sample_req(32'sh7ffffffe));
    pending_reqs.push_back(sample_req(32'sh80000001));
    pending_reqs.push_back(sample_req(plan_key[1] - 1));
    pending_reqs.push_back(sample_req(plan_key[1]));
    pending_reqs.push_back(sample_req(plan_key[1] + 1));
    pending_reqs.push_back(sample_req(plan_key[2] - 1));
    pending_reqs.push_back(sample_req(plan_key[32]));
    pending_reqs.push_back(sample_req(plan_key[62] + step / 2));
    pending_reqs.push_back(sample_req(32'sd0));
    pending_reqs.push_back(sample_req(32'shffffffff));
    wait_drained();
    // A key out of order: the search must still stay inside a valid segment.
    pending_reqs.push_back(write_req(10, plan_key[40], 32'sd12345));
    pending_reqs.push_back(sample_req(plan_key[10] - 5));
    pending_reqs.push_back(sample_req(plan_key[40] + 5));
    pending_reqs.push_back(write_req(10, -32'sd2147483648 + 32'(10 * step), 32'sd12345));
    wait_drained();
    // A single point and a zero count both clamp everything to the first point.
    set_points_in_use(7'd1);
    pending_reqs.push_back(sample_req(32'sd7));
    wait_drained();
    set_points_in_use(7'd0);
    pending_reqs.push_back(sample_req(32'sh80000000));
    pending_reqs.push_back(sample_req(32'sh7fffffff));
    wait_drained();

    // Random phases over several point counts and idling patterns.
    run_phase(7'd64, 0, 0, 60);
    run_phase(7'd2, 87, 0, 70);
    run_phase(7'd127, 0, 87, 70);
    run_phase(7'd0, 37, 37, 50);
    run_phase(7'd65, 87, 0, 70);
    run_phase(7'd33, 0, 87, 70);
    run_phase(7'($urandom_range(3, 63)), 37, 37, 70);

    // Back-pressure: a long receiver hold-off while the sender keeps offering items.
    set_points_in_use(7'd64);
    @(posedge clk);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_go        <= 1'b1;
    repeat (60) pending_reqs.push_back(random_req());
    @(posedge clk);
    while (hold_cnt == 0) @(posedge clk);
    hold_go <= 1'b0;
    // Sender pause: nothing new until every outstanding result has come back.
    wait_drained();
    repeat (60) pending_reqs.push_back(random_req());
    wait_drained();

    $display("Covered %0d samples and %0d point writes, %0d results checked,",
             samples_sent, writes_sent, results_seen);
    $display("point counts from zero to beyond the table, idling, stalls and long hold-off.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
